[rtl/core/maf_pkg.sv]
// ----------------------------------------------------------------------------
// maf_pkg
// Shared widths and register map of the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

  // sample and window field widths
  localparam int SAMPLE_W = 16;
  localparam int WIN_W    = 11;
  localparam int WIN_MAX  = (1 << WIN_W) - 1;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register indexes, placed at byte address 4*index
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  // mode register codes
  localparam logic MODE_LOWPASS  = 1'b0;
  localparam logic MODE_HIGHPASS = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

[rtl/core/maf_ram.sv]
// ----------------------------------------------------------------------------
// maf_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/moving_average_filter.sv]
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average (or sample minus average) over the last N signed 16-bit samples.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. With the filter disabled an accepted
// sample goes straight to the result step. With the filter enabled the oldest
// ring entry is read from the sample RAM in the cycle the sample is accepted,
// then the running sum is updated and the new sample written back, then the
// restoring divider retires one quotient bit per cycle, and last the result is
// formed and saturated once the output register is free. The result sits in an
// output register, so the next sample is taken while it waits.
// Writing window_size clears the ring at once: a lap flag marks whether the
// ring has wrapped since the clear, and entries not yet written read as zero,
// so there is no clearing pass after reset or after a window write.
// ----------------------------------------------------------------------------
module moving_average_filter
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic signed [15:0]  sample,
  // result channel
  output logic                filtered_valid,
  input  logic                filtered_ready,
  output logic signed [15:0]  filtered,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NMAX  = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
  localparam int SUM_W = SAMPLE_W + ((NMAX > 1) ? $clog2(NMAX) : 0);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int RES_W = SUM_W + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // configuration registers
  logic             enable;
  logic             mode;
  logic [WIN_W-1:0] window_size;

  // filter state
  logic [IDX_W-1:0]        pos;
  logic                    wrapped;
  logic signed [SUM_W-1:0] sum;

  // transaction registers
  logic [1:0]       state;
  logic             bypass;
  sample_t          s_reg;
  logic             neg;
  logic [SUM_W-1:0] dvd;
  logic [WIN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;

  // ring memory
  logic    ram_we;
  sample_t ram_rdata;

  logic                    cfg_wr;
  logic [WIN_W-1:0]        win_eff;
  logic                    pos_wrap;
  sample_t                 old_val;
  logic signed [SUM_W-1:0] sum_next;
  logic [WIN_W:0]          shifted;
  logic                    q_bit;
  logic [WIN_W:0]          rem_sub;
  logic signed [RES_W-1:0] mean;
  logic signed [RES_W-1:0] res_wide;
  sample_t                 res_sat;
  logic                    out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // read back
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_ENABLE: prdata = APB_DW'(enable);
      REG_MODE:   prdata = APB_DW'(mode);
      REG_WINDOW: prdata = APB_DW'(window_size);
      default:    prdata = '0;
    endcase
  end

  // window length in use, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      win_eff = WIN_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      win_eff = WIN_W'(NMAX);
    end else begin
      win_eff = window_size;
    end
  end

  assign sample_ready = (state == ST_IDLE);
  assign out_free     = !filtered_valid || filtered_ready;

  // sum update, oldest entry reads as zero until the ring has wrapped
  assign old_val  = wrapped ? ram_rdata : '0;
  assign sum_next = sum - SUM_W'(old_val) + SUM_W'(s_reg);
  assign pos_wrap = (int'(pos) + 1) >= int'(win_eff);
  assign ram_we   = (state == ST_UPD);

  // one restoring divider step
  assign shifted = {rem, dvd[SUM_W-1]};
  assign q_bit   = (shifted >= {1'b0, win_eff});
  assign rem_sub = shifted - {1'b0, win_eff};

  // result forming and saturation
  always_comb begin
    mean = neg ? -RES_W'({1'b0, dvd}) : RES_W'({1'b0, dvd});
    if (bypass) begin
      res_wide = RES_W'(s_reg);
    end else if (mode == MODE_HIGHPASS) begin
      res_wide = RES_W'(s_reg) - mean;
    end else begin
      res_wide = mean;
    end
    if (res_wide > RES_W'(32767)) begin
      res_sat = 16'sh7fff;
    end else if (res_wide < -RES_W'(32768)) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res_wide[SAMPLE_W-1:0];
    end
  end

  maf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (s_reg),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // configuration and ring control
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      mode        <= MODE_LOWPASS;
      window_size <= WIN_W'(1);
      pos         <= '0;
      wrapped     <= 1'b0;
      sum         <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ENABLE: enable <= pwdata[0];
          REG_MODE:   mode   <= pwdata[0];
          REG_WINDOW: begin
            window_size <= pwdata[WIN_W-1:0];
            pos         <= '0;
            wrapped     <= 1'b0;
            sum         <= '0;
          end
          default: ;
        endcase
      end
      if (state == ST_UPD) begin
        sum <= sum_next;
        if (pos_wrap) begin
          pos     <= '0;
          wrapped <= 1'b1;
        end else begin
          pos <= pos + IDX_W'(1);
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      filtered_valid <= 1'b0;
    end else begin
      // result register load or drain
      if (state == ST_FIN && out_free) begin
        filtered_valid <= 1'b1;
      end else if (filtered_valid && filtered_ready) begin
        filtered_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            state <= enable ? ST_UPD : ST_FIN;
          end
        end
        ST_UPD: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      s_reg  <= sample;
      bypass <= !enable;
    end
    if (state == ST_UPD) begin
      neg <= sum_next[SUM_W-1];
      dvd <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
      rem <= '0;
      cnt <= CNT_W'(SUM_W);
    end
    if (state == ST_DIV) begin
      rem <= q_bit ? rem_sub[WIN_W-1:0] : shifted[WIN_W-1:0];
      dvd <= {dvd[SUM_W-2:0], q_bit};
      cnt <= cnt - CNT_W'(1);
    end
    if (state == ST_FIN && out_free) begin
      filtered <= res_sat;
    end
  end

endmodule

[rtl/core/maf_checker.sv]
// ----------------------------------------------------------------------------
// maf_checker
// Port level checks of the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module maf_checker
  import maf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_ready,
  input logic                filtered_valid,
  input logic                filtered_ready,
  input logic signed [15:0]  filtered,
  input logic                psel,
  input logic                pwrite,
  input logic [APB_AW-1:0]   paddr,
  input logic [APB_DW-1:0]   prdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    filtered_valid && !filtered_ready |=> filtered_valid && $stable(filtered))
    else $error("result changed while stalled");

  // one sample in flight: no new transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while another is in flight");

  // a result appears only after the sample side was busy
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(filtered_valid) |-> !$past(sample_ready))
    else $error("result without a sample in flight");

  // window register reads back within its field width
  a_window_width: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && paddr[3:2] == REG_WINDOW |-> prdata[APB_DW-1:WIN_W] == '0)
    else $error("window read back wider than its field");

endmodule

bind moving_average_filter maf_checker u_maf_checker (.*);
